// ----- hw/rtl/gray_level_histogram_macros.svh -----
// ----------------------------------------------------------------------------
// gray_level_histogram_macros
// Assertion macros shared by the histogram checker.
// ----------------------------------------------------------------------------
`ifndef GRAY_LEVEL_HISTOGRAM_MACROS_SVH
`define GRAY_LEVEL_HISTOGRAM_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GLH_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define GLH_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ghist_pkg.sv -----
// ----------------------------------------------------------------------------
// ghist_pkg
// Types, widths and constants of the gray-level histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package ghist_pkg;

    // field widths
    localparam int CH_W       = 8;
    localparam int GRAY_W     = 8;
    localparam int WEIGHT_W   = 9;
    localparam int COUNT_W    = 23;
    localparam int REQ_W      = 2;
    localparam int FRAC_W     = 8;
    localparam int PROD_W     = CH_W + WEIGHT_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int LEVEL_W    = SUM_W - FRAC_W;
    localparam int BINS       = 256;
    localparam int BIN_W      = $clog2(BINS);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = WEIGHT_W;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE  = CFG_IDX_W'(2);

    // weight reset values, Q1.8
    localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = WEIGHT_W'(77);
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = WEIGHT_W'(150);
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = WEIGHT_W'(29);

    // bin count cap: MAX_PIXELS, limited to the count width
    localparam longint MAX_PIXELS  = 4194304;
    localparam longint COUNT_MAX   = (longint'(1) << COUNT_W) - 1;
    localparam longint COUNT_CAP   = (MAX_PIXELS > COUNT_MAX) ? COUNT_MAX : MAX_PIXELS;
    localparam logic [COUNT_W-1:0] COUNT_CAP_V = COUNT_W'(COUNT_CAP);

    localparam logic [GRAY_W-1:0] GRAY_SAT = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PIXEL,
        REQ_READ,
        REQ_CLEAR,
        REQ_NOP
    } req_type_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_SUM,
        S_READ,
        S_UPDATE,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mult;
        logic sum;
        logic rd;
        logic update;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        req_type_t req_type;
        logic      out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ghist_in_if.sv -----
// ----------------------------------------------------------------------------
// ghist_in_if
// Request channel: pixel, bin read or clear words with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ghist_in_if;
    logic                        valid;
    logic                        ready;
    logic [ghist_pkg::REQ_W-1:0] req_type;
    logic [ghist_pkg::CH_W-1:0]  red;
    logic [ghist_pkg::CH_W-1:0]  green;
    logic [ghist_pkg::CH_W-1:0]  blue;
    logic [ghist_pkg::BIN_W-1:0] bin_index;

    modport source (output valid, req_type, red, green, blue, bin_index, input ready);
    modport sink   (input valid, req_type, red, green, blue, bin_index, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ghist_out_if.sv -----
// ----------------------------------------------------------------------------
// ghist_out_if
// Result channel: gray level and bin count words with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ghist_out_if;
    logic                          valid;
    logic                          ready;
    logic [ghist_pkg::GRAY_W-1:0]  gray_value;
    logic [ghist_pkg::COUNT_W-1:0] bin_count;

    modport source (output valid, gray_value, bin_count, input ready);
    modport sink   (input valid, gray_value, bin_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gray_level_histogram.sv -----
// ----------------------------------------------------------------------------
// gray_level_histogram
// RGB to gray conversion with a 256-bin histogram, bin reads and clear.
//
//   channel  dir  words
//   req      in   req_type, red, green, blue, bin_index
//   rsp      out  gray_value, bin_count
//   cfg      in   cfg_we, cfg_index, cfg_data (weights, write only)
//
// One request word at a time: the sequencer steps a pixel through multiply,
// sum, bin RAM read and update, a bin read skips the sum, and a clear or
// no-op goes from multiply straight to update. The result sits in an output
// register, so a new word is taken while the last result waits. Reset clears
// the bins at once through per-bin valid bits; no clearing pass. A stalled
// result holds only the last step of the following word.
// ----------------------------------------------------------------------------
`default_nettype none

module gray_level_histogram (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    ghist_in_if.sink                              req,
    ghist_out_if.source                           rsp,
    input  wire logic                             cfg_we,
    input  wire logic [ghist_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ghist_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ghist_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    ghist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    ghist_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_req_type    (req.req_type),
        .in_red         (req.red),
        .in_green       (req.green),
        .in_blue        (req.blue),
        .in_bin_index   (req.bin_index),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_gray_value (rsp.gray_value),
        .out_bin_count  (rsp.bin_count)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ghist_ram.sv -----
// ----------------------------------------------------------------------------
// ghist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ghist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ghist_ctrl.sv -----
// ----------------------------------------------------------------------------
// ghist_ctrl
// Sequencer: steps one request word through convert, lookup, update and
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ghist_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ghist_pkg::dp_status_t status,
    output ghist_pkg::ctrl_cmd_t       cmd
);
    import ghist_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                cmd.mult = 1'b1;
                case (status.req_type)
                    REQ_PIXEL: state_next = S_SUM;
                    REQ_READ:  state_next = S_READ;
                    default:   state_next = S_UPDATE;
                endcase
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ghist_dp.sv -----
// ----------------------------------------------------------------------------
// ghist_dp
// Datapath: weight registers, gray conversion, bin store with valid bits,
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ghist_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ghist_pkg::ctrl_cmd_t             cmd,
    output ghist_pkg::dp_status_t                 status,
    input  wire logic                             cfg_we,
    input  wire logic [ghist_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ghist_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [ghist_pkg::REQ_W-1:0]      in_req_type,
    input  wire logic [ghist_pkg::CH_W-1:0]       in_red,
    input  wire logic [ghist_pkg::CH_W-1:0]       in_green,
    input  wire logic [ghist_pkg::CH_W-1:0]       in_blue,
    input  wire logic [ghist_pkg::BIN_W-1:0]      in_bin_index,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic [ghist_pkg::GRAY_W-1:0]          out_gray_value,
    output logic [ghist_pkg::COUNT_W-1:0]         out_bin_count
);
    import ghist_pkg::*;

    logic [WEIGHT_W-1:0] weight_red_reg;
    logic [WEIGHT_W-1:0] weight_green_reg;
    logic [WEIGHT_W-1:0] weight_blue_reg;

    req_type_t           req_type_reg;
    logic [CH_W-1:0]     red_reg;
    logic [CH_W-1:0]     green_reg;
    logic [CH_W-1:0]     blue_reg;
    logic [BIN_W-1:0]    bin_index_reg;

    logic [PROD_W-1:0]   prod_red_reg;
    logic [PROD_W-1:0]   prod_green_reg;
    logic [PROD_W-1:0]   prod_blue_reg;
    logic [SUM_W-1:0]    sum;
    logic [LEVEL_W-1:0]  level;
    logic [GRAY_W-1:0]   gray_next;
    logic [GRAY_W-1:0]   gray_reg;

    logic [BINS-1:0]     bin_valid_reg;
    logic [BIN_W-1:0]    bin_addr;
    logic [COUNT_W-1:0]  ram_rdata;
    logic [COUNT_W-1:0]  cur_count;
    logic                is_pixel;
    logic                bin_we;

    logic [GRAY_W-1:0]   res_gray_reg;
    logic [COUNT_W-1:0]  res_count_reg;

    logic                out_valid_reg;
    logic [GRAY_W-1:0]   out_gray_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    // weight registers, out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_red_reg   <= WEIGHT_RED_RST;
            weight_green_reg <= WEIGHT_GREEN_RST;
            weight_blue_reg  <= WEIGHT_BLUE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WEIGHT_RED:   weight_red_reg   <= cfg_data;
                REG_WEIGHT_GREEN: weight_green_reg <= cfg_data;
                REG_WEIGHT_BLUE:  weight_blue_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // request word capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_type_reg  <= req_type_t'(in_req_type);
            red_reg       <= in_red;
            green_reg     <= in_green;
            blue_reg      <= in_blue;
            bin_index_reg <= in_bin_index;
        end
    end

    // weighted products
    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            prod_red_reg   <= PROD_W'(red_reg)   * PROD_W'(weight_red_reg);
            prod_green_reg <= PROD_W'(green_reg) * PROD_W'(weight_green_reg);
            prod_blue_reg  <= PROD_W'(blue_reg)  * PROD_W'(weight_blue_reg);
        end
    end

    // sum, drop fraction, saturate
    assign sum = SUM_W'(prod_red_reg) + SUM_W'(prod_green_reg) + SUM_W'(prod_blue_reg);
    assign level = sum[SUM_W-1:FRAC_W];
    assign gray_next = (|level[LEVEL_W-1:GRAY_W]) ? GRAY_SAT : level[GRAY_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            gray_reg <= gray_next;
        end
    end

    // bin lookup and read-modify-write
    assign is_pixel  = (req_type_reg == REQ_PIXEL);
    assign bin_addr  = is_pixel ? gray_reg : bin_index_reg;
    assign cur_count = bin_valid_reg[bin_addr] ? ram_rdata : '0;
    assign bin_we    = cmd.update && is_pixel && (cur_count < COUNT_CAP_V);

    ghist_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BINS)
    ) u_bins (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_addr),
        .wdata (cur_count + COUNT_W'(1)),
        .re    (cmd.rd),
        .raddr (bin_addr),
        .rdata (ram_rdata)
    );

    // bin valid bits: an invalid bin reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
        end
        else if (cmd.update && (req_type_reg == REQ_CLEAR))
        begin
            bin_valid_reg <= '0;
        end
        else if (bin_we)
        begin
            bin_valid_reg[bin_addr] <= 1'b1;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            res_gray_reg  <= is_pixel ? gray_reg : '0;
            res_count_reg <= (req_type_reg == REQ_READ) ? cur_count : '0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_gray_reg  <= res_gray_reg;
            out_count_reg <= res_count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_gray_value = out_gray_reg;
    assign out_bin_count  = out_count_reg;

    assign status.req_type = req_type_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/ghist_checker.sv -----
// ----------------------------------------------------------------------------
// ghist_checker
// Port-level checks of the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gray_level_histogram_macros.svh"

module ghist_sva (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [ghist_pkg::GRAY_W-1:0]  rsp_gray_value,
    input wire logic [ghist_pkg::COUNT_W-1:0] rsp_bin_count
);
    import ghist_pkg::*;

    // stalled result word holds
    `GLH_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_gray_value) && $stable(rsp_bin_count),
        "result word changed under stall")

    // one request in flight: no accept on the cycle after an accept
    `GLH_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready,
        "request taken while one is in flight")

    // a result carries a gray level or a count, never both
    `GLH_ASSERT_SAME(a_one_field, clk, rst_n, rsp_valid,
        (rsp_gray_value == '0) || (rsp_bin_count == '0), "both result fields nonzero")

    // bin counts never pass the cap
    `GLH_ASSERT_SAME(a_count_cap, clk, rst_n, rsp_valid, rsp_bin_count <= COUNT_CAP_V,
        "bin count above cap")

endmodule

bind gray_level_histogram ghist_sva u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_gray_value (rsp.gray_value),
    .rsp_bin_count  (rsp.bin_count)
);

`default_nettype wire

// ----- verif/ghist_checker.sv -----
// ----------------------------------------------------------------------------
// ghist_checker
// Watches the request, result and register ports of the gray-level histogram,
// keeps its own copy of the weights and bin counts, predicts one result word
// per accepted request and compares every accepted result word in order.
// ----------------------------------------------------------------------------
module ghist_checker
    import ghist_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    ghist_in_if                   req_mon,
    ghist_out_if                  rsp_mon,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    results_due,
    output int                    error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [GRAY_W-1:0]  gray;
        logic [COUNT_W-1:0] count;
    } hist_word_t;

    // predicted result words, oldest first
    hist_word_t          due_words[$];

    // shadow of the weight registers and the bin store
    logic [WEIGHT_W-1:0] w_red;
    logic [WEIGHT_W-1:0] w_green;
    logic [WEIGHT_W-1:0] w_blue;
    logic [COUNT_W-1:0]  hist_bins [BINS];
    int                  fails;

    // weighted sum, drop the fraction, saturate at full scale
    function automatic logic [GRAY_W-1:0] gray_of(input logic [CH_W-1:0] r,
                                                  input logic [CH_W-1:0] g,
                                                  input logic [CH_W-1:0] b);
        int unsigned wsum;
        int unsigned lvl;
        wsum = int'(r) * int'(w_red) + int'(g) * int'(w_green) + int'(b) * int'(w_blue);
        lvl  = wsum >> FRAC_W;
        return (lvl > 255) ? GRAY_SAT : GRAY_W'(lvl);
    endfunction

    // update the bin store for one request and return its result word
    function automatic hist_word_t run_request(input req_type_t      kind,
                                               input logic [CH_W-1:0] r,
                                               input logic [CH_W-1:0] g,
                                               input logic [CH_W-1:0] b,
                                               input logic [BIN_W-1:0] idx);
        hist_word_t w;
        w = '0;
        case (kind)
            REQ_PIXEL:
            begin
                w.gray = gray_of(r, g, b);
                // a full bin stays where it is
                if (hist_bins[w.gray] < COUNT_CAP_V)
                    hist_bins[w.gray] = hist_bins[w.gray] + 1'b1;
            end
            REQ_READ:
                w.count = hist_bins[idx];
            REQ_CLEAR:
                for (int i = 0; i < BINS; i++)
                    hist_bins[i] = '0;
            default:
                w = '0;
        endcase
        return w;
    endfunction

    // sample all ports at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        hist_word_t got;
        hist_word_t want;
        if (!rst_n)
        begin
            w_red   = WEIGHT_RED_RST;
            w_green = WEIGHT_GREEN_RST;
            w_blue  = WEIGHT_BLUE_RST;
            for (int i = 0; i < BINS; i++)
                hist_bins[i] = '0;
            due_words.delete();
            fails        = 0;
            results_due <= 0;
            error_count <= 0;
        end
        else
        begin
            // result word against the oldest prediction
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got.gray  = rsp_mon.gray_value;
                got.count = rsp_mon.bin_count;
                if (due_words.size() == 0)
                begin
                    $display("%0t ns: unexpected result word, expected none, actual gray %0d count %0d",
                             $time, got.gray, got.count);
                    fails++;
                end
                else
                begin
                    want = due_words.pop_front();
                    if (got.gray !== want.gray)
                    begin
                        $display("%0t ns: gray_value mismatch, expected %0d, actual %0d",
                                 $time, want.gray, got.gray);
                        fails++;
                    end
                    if (got.count !== want.count)
                    begin
                        $display("%0t ns: bin_count mismatch, expected %0d, actual %0d",
                                 $time, want.count, got.count);
                        fails++;
                    end
                end
            end

            // request word
            if (req_mon.valid && req_mon.ready)
                due_words.push_back(run_request(req_type_t'(req_mon.req_type), req_mon.red,
                                                req_mon.green, req_mon.blue,
                                                req_mon.bin_index));

            // weight register write, unused index ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WEIGHT_RED:   w_red   = cfg_data;
                    REG_WEIGHT_GREEN: w_green = cfg_data;
                    REG_WEIGHT_BLUE:  w_blue  = cfg_data;
                    default:          ;
                endcase
            end

            results_due <= due_words.size();
            error_count <= fails;
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the gray-level histogram: a directed pass over the corner
// pixels, bin reads, clears and no-ops, then random request words in bursts
// under several weight settings, with a stalling result receiver. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ghist_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
    localparam int PHASES     = 6;
    localparam int PHASE_ITEMS = 170;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    results_due;
    int                    error_count;

    // gray levels that reads aim at, so that bins with counts get read back
    logic [GRAY_W-1:0]     hot_levels [8];

    // receiver stall pattern state
    int                    stall_mode = 0;
    int                    mode_left  = 0;
    int                    rx_tick    = 0;

    ghist_in_if  req_ch ();
    ghist_out_if rsp_ch ();

    gray_level_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ghist_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_mon     (req_ch),
        .rsp_mon     (rsp_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .results_due (results_due),
        .error_count (error_count)
    );

    always #5 clk = ~clk;

    // result receiver: switches between stall patterns
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 80);
        end
        mode_left--;
        rx_tick++;
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ch.ready <= ((rx_tick % 7) < 3);
        endcase
    end

    // one request word, held until accepted
    task automatic send_word(input req_type_t kind, input logic [CH_W-1:0] r,
                             input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                             input logic [BIN_W-1:0] idx);
        @(negedge clk);
        req_ch.valid     = 1'b1;
        req_ch.req_type  = kind;
        req_ch.red       = r;
        req_ch.green     = g;
        req_ch.blue      = b;
        req_ch.bin_index = idx;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // sender gap, payload scrambled while not valid
    task automatic pause(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            req_ch.valid     = 1'b0;
            req_ch.req_type  = REQ_W'($urandom);
            req_ch.red       = CH_W'($urandom);
            req_ch.green     = CH_W'($urandom);
            req_ch.blue      = CH_W'($urandom);
            req_ch.bin_index = BIN_W'($urandom);
        end
    endtask

    // block drained: all result words back
    task automatic wait_idle();
        pause(1);
        do
            @(negedge clk);
        while (results_due != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic set_weights(input logic [WEIGHT_W-1:0] wr, input logic [WEIGHT_W-1:0] wg,
                               input logic [WEIGHT_W-1:0] wb);
        wait_idle();
        write_reg(REG_WEIGHT_RED, wr);
        write_reg(REG_WEIGHT_GREEN, wg);
        write_reg(REG_WEIGHT_BLUE, wb);
    endtask

    // random request word: mostly pixels and reads, few clears
    task automatic send_random_word();
        int                pick;
        logic [CH_W-1:0]   v;
        logic [BIN_W-1:0]  idx;
        pick = $urandom_range(0, 99);
        v    = hot_levels[$urandom_range(0, 7)];
        idx  = ($urandom_range(0, 1) != 0) ? v : BIN_W'($urandom);
        if (pick < 30)
            send_word(REQ_PIXEL, v, v, v, BIN_W'($urandom));
        else if (pick < 62)
            send_word(REQ_PIXEL, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                      BIN_W'($urandom));
        else if (pick < 90)
            send_word(REQ_READ, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), idx);
        else if (pick < 98)
            send_word(REQ_NOP, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                      BIN_W'($urandom));
        else
            send_word(REQ_CLEAR, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                      BIN_W'($urandom));
    endtask

    // run limit
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int items_left;
        int burst;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = '0;
        req_ch.red       = '0;
        req_ch.green     = '0;
        req_ch.blue      = '0;
        req_ch.bin_index = '0;
        rsp_ch.ready     = 1'b0;
        hot_levels[0] = '0;
        hot_levels[1] = '1;
        for (int i = 2; i < 8; i++)
            hot_levels[i] = GRAY_W'($urandom);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner pixels under the reset weights
        send_word(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255);
        send_word(REQ_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0);
        send_word(REQ_PIXEL, 8'd255, 8'd0, 8'd0, 8'd0);
        send_word(REQ_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0);
        send_word(REQ_PIXEL, 8'd0, 8'd0, 8'd255, 8'd0);
        send_word(REQ_PIXEL, 8'd128, 8'd128, 8'd128, 8'd0);
        send_word(REQ_PIXEL, 8'd128, 8'd128, 8'd128, 8'd0);
        // bin reads, including a bin never counted
        send_word(REQ_READ, 8'd255, 8'd255, 8'd255, 8'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd255);
        send_word(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd128);
        send_word(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd76);
        send_word(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd1);
        // no-op with all fields high and low
        send_word(REQ_NOP, 8'd255, 8'd255, 8'd255, 8'd255);
        send_word(REQ_NOP, 8'd0, 8'd0, 8'd0, 8'd0);
        // clear, then the bins read back empty
        send_word(REQ_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255);
        send_word(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd128);
        send_word(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0);

        // weights past full scale: sum saturates
        set_weights('1, '1, '1);
        send_word(REQ_PIXEL, 8'd1, 8'd0, 8'd0, 8'd0);
        send_word(REQ_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0);
        send_word(REQ_PIXEL, 8'd0, 8'd0, 8'd1, 8'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd255);

        // zero weights: everything lands in bin zero
        set_weights('0, '0, '0);
        send_word(REQ_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd0);

        // red only, and a write to the unused index changes nothing
        set_weights(9'd256, 9'd0, 9'd0);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        send_word(REQ_PIXEL, 8'd200, 8'd9, 8'd9, 8'd0);
        send_word(REQ_READ, 8'd0, 8'd0, 8'd0, 8'd200);

        // random bursts under a different weight setting per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: set_weights(WEIGHT_RED_RST, WEIGHT_GREEN_RST, WEIGHT_BLUE_RST);
                1: set_weights(WEIGHT_W'($urandom_range(0, 256)),
                               WEIGHT_W'($urandom_range(0, 256)),
                               WEIGHT_W'($urandom_range(0, 256)));
                2: set_weights(9'd256, 9'd256, 9'd256);
                3: set_weights(WEIGHT_W'($urandom_range(0, 511)),
                               WEIGHT_W'($urandom_range(0, 511)),
                               WEIGHT_W'($urandom_range(0, 511)));
                4: set_weights(9'd0, 9'd256, WEIGHT_W'($urandom_range(0, 256)));
                default: set_weights(WEIGHT_W'($urandom_range(0, 256)),
                                     WEIGHT_W'($urandom_range(0, 256)),
                                     WEIGHT_W'($urandom_range(0, 256)));
            endcase
            items_left = PHASE_ITEMS;
            while (items_left > 0)
            begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && items_left > 0)
                begin
                    send_random_word();
                    burst--;
                    items_left--;
                end
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 12));
            end
        end

        // drain and verdict
        pause(1);
        do
            @(negedge clk);
        while (results_due != 0);
        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ghist_pkg.sv
hw/rtl/ghist_in_if.sv
hw/rtl/ghist_out_if.sv
hw/rtl/ghist_ram.sv
hw/rtl/ghist_ctrl.sv
hw/rtl/ghist_dp.sv
hw/rtl/gray_level_histogram.sv
hw/rtl/ghist_checker.sv
verif/ghist_checker.sv
verif/tb_top.sv
